/* sv/acpu_pkg.sv */
// Package for the accumulator CPU: opcodes, states, sizes.
// No dependencies.
package acpu_pkg;
  localparam int MEM_WORDS_DEF = 2000;
  localparam logic [31:0] USER_TOP     = 32'd999;
  localparam logic [31:0] USER_SP_RST  = 32'd1000;
  localparam logic [31:0] TIMER_VEC_M1 = 32'd999;
  localparam logic [31:0] SYS_VEC_M1   = 32'd1499;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_END    = 2'd1;
  localparam logic [1:0] ST_FAULT  = 2'd2;
  localparam logic [1:0] ST_HALTED = 2'd3;

  localparam logic [31:0] OP_LDV  = 32'd1;
  localparam logic [31:0] OP_LDA  = 32'd2;
  localparam logic [31:0] OP_LDI  = 32'd3;
  localparam logic [31:0] OP_LDX  = 32'd4;
  localparam logic [31:0] OP_LDY  = 32'd5;
  localparam logic [31:0] OP_LDSP = 32'd6;
  localparam logic [31:0] OP_ST   = 32'd7;
  localparam logic [31:0] OP_GET  = 32'd8;
  localparam logic [31:0] OP_PUT  = 32'd9;
  localparam logic [31:0] OP_ADDX = 32'd10;
  localparam logic [31:0] OP_ADDY = 32'd11;
  localparam logic [31:0] OP_SUBX = 32'd12;
  localparam logic [31:0] OP_SUBY = 32'd13;
  localparam logic [31:0] OP_TOX  = 32'd14;
  localparam logic [31:0] OP_FRX  = 32'd15;
  localparam logic [31:0] OP_TOY  = 32'd16;
  localparam logic [31:0] OP_FRY  = 32'd17;
  localparam logic [31:0] OP_TOSP = 32'd18;
  localparam logic [31:0] OP_FRSP = 32'd19;
  localparam logic [31:0] OP_JMP  = 32'd20;
  localparam logic [31:0] OP_JEQ  = 32'd21;
  localparam logic [31:0] OP_JNE  = 32'd22;
  localparam logic [31:0] OP_CALL = 32'd23;
  localparam logic [31:0] OP_RET  = 32'd24;
  localparam logic [31:0] OP_INCX = 32'd25;
  localparam logic [31:0] OP_DECX = 32'd26;
  localparam logic [31:0] OP_PUSH = 32'd27;
  localparam logic [31:0] OP_POP  = 32'd28;
  localparam logic [31:0] OP_INT  = 32'd29;
  localparam logic [31:0] OP_IRET = 32'd30;
  localparam logic [31:0] OP_END  = 32'd50;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_DEC, S_RD1, S_RD2, S_RD3, S_WR, S_IRQ1, S_IRQ2, S_POST, S_DONE
  } state_t;
endpackage

/* sv/acpu_mem.sv */
// Single-port main memory with registered read data.
// Depends on nothing but its parameter.
module acpu_mem #(
  parameter int MEM_WORDS = 2000
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(MEM_WORDS)-1:0] addr,
  input  logic [31:0]                  wdata,
  output logic [31:0]                  rdata
);
  logic [31:0] mem [MEM_WORDS];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    else rdata <= mem[addr];
  end
endmodule

/* sv/accumulator_cpu_with_timer_irq.sv */
// Top level of the accumulator CPU with timer interrupt.
// Depends on acpu_pkg and acpu_mem.
//
// Usage: raise start with in_command and its fields while busy is low; the
// request is taken at that edge and busy rises. A load request writes one
// memory word, unless its address is at or above the memory size, and then
// answers. A step request fetches and runs one instruction: every memory
// access (fetch, operand, indirection, store, stack) goes through the one
// memory port, whose read data is registered; a timer interrupt adds its
// two stack writes to the step that raises it. Exactly one result per
// request is shown for one cycle with out_strobe high; the receiver cannot
// stall it. busy falls in the cycle after the result, so the next request
// can be taken no earlier than the cycle after the answer.
// cfg_valid/cfg_ready write timer_period; cfg_ready is high while idle.
// Reset (rst_n low, synchronous) sets all registers but the request capture,
// t and sv: pc 0, sp 1000, user mode, not halted, timer_period 0. Memory
// content is undefined until loaded; no clearing pass is run.
// Step addresses are checked against the memory size and, in user mode, 999;
// any failing access halts the CPU with status 2.
module accumulator_cpu_with_timer_irq #(
  parameter int MEM_WORDS = acpu_pkg::MEM_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic [10:0]        in_load_address,
  input  logic signed [31:0] in_load_data,
  input  logic [6:0]         in_random_value,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic               out_valid,
  output logic               out_is_char,
  output logic signed [31:0] out_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_timer_period
);
  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [31:0] MEM_TOP = 32'(MEM_WORDS);

  acpu_pkg::state_t st_r, st_nxt;
  logic [31:0] pc_r, pc_nxt, acc_r, acc_nxt, x_r, x_nxt, y_r, y_nxt, sp_r, sp_nxt;
  logic [31:0] ir_r, ir_nxt, cnt_r, cnt_nxt, t_r, t_nxt, sv_r, sv_nxt;
  logic        sys_r, sys_nxt, tirq_r, tirq_nxt, halt_r, halt_nxt;
  logic [15:0] period_r;
  logic [1:0]  ph_r, ph_nxt;             // access step within instruction
  logic        put_r, put_nxt, ischar_r, ischar_nxt;
  logic [6:0]  rnd_r;
  logic        cmd_r;
  logic [10:0] la_r;
  logic [31:0] ld_r;
  logic [1:0]  stat_r, stat_nxt;

  // shared memory port
  logic        m_we;
  logic [31:0] m_a, m_wd, m_rd;
  logic        a_ok;

  acpu_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
    .clk(clk), .we(m_we), .addr(m_a[AW-1:0]), .wdata(m_wd), .rdata(m_rd)
  );

  // the one shared address checker
  assign a_ok = (m_a < MEM_TOP) && (sys_r || m_a <= acpu_pkg::USER_TOP);

  assign busy      = (st_r != acpu_pkg::S_IDLE);
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) period_r <= '0;
    else if (cfg_valid && cfg_ready) period_r <= cfg_timer_period;
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r <= in_command;
      la_r  <= in_load_address;
      ld_r  <= in_load_data;
      rnd_r <= in_random_value;
    end
  end

  // next-state and datapath
  always_comb begin
    st_nxt = st_r; pc_nxt = pc_r; acc_nxt = acc_r; x_nxt = x_r; y_nxt = y_r;
    sp_nxt = sp_r; ir_nxt = ir_r; cnt_nxt = cnt_r; t_nxt = t_r; sv_nxt = sv_r;
    sys_nxt = sys_r; tirq_nxt = tirq_r; halt_nxt = halt_r; ph_nxt = ph_r;
    put_nxt = put_r; ischar_nxt = ischar_r; stat_nxt = stat_r;
    m_a = '0; m_wd = '0; m_we = 1'b0;
    case (st_r)
      acpu_pkg::S_IDLE: begin
        if (start) begin
          put_nxt = 1'b0; ischar_nxt = 1'b0; ph_nxt = '0;
          st_nxt = acpu_pkg::S_FETCH;
        end
      end
      acpu_pkg::S_FETCH: begin
        if (!cmd_r) begin
          m_a = {21'd0, la_r};
          m_wd = ld_r;
          m_we = (32'({21'd0, la_r}) < MEM_TOP);
          stat_nxt = halt_r ? acpu_pkg::ST_HALTED : acpu_pkg::ST_OK;
          st_nxt = acpu_pkg::S_DONE;
        end else if (halt_r) begin
          stat_nxt = acpu_pkg::ST_HALTED;
          st_nxt = acpu_pkg::S_DONE;
        end else begin
          m_a = pc_r;
          if (!a_ok) begin
            halt_nxt = 1'b1; stat_nxt = acpu_pkg::ST_FAULT; st_nxt = acpu_pkg::S_DONE;
          end else st_nxt = acpu_pkg::S_DEC;
        end
      end
      acpu_pkg::S_DEC: begin
        ir_nxt = m_rd;
        st_nxt = acpu_pkg::S_POST;
        case (m_rd)
          acpu_pkg::OP_LDV, acpu_pkg::OP_LDA, acpu_pkg::OP_LDI, acpu_pkg::OP_LDX,
          acpu_pkg::OP_LDY, acpu_pkg::OP_ST, acpu_pkg::OP_PUT: begin
            pc_nxt = pc_r + 32'd1; t_nxt = pc_r + 32'd1; st_nxt = acpu_pkg::S_RD1;
          end
          acpu_pkg::OP_LDSP: begin t_nxt = x_r + sp_r; st_nxt = acpu_pkg::S_RD1; end
          acpu_pkg::OP_GET:  acc_nxt = {25'd0, rnd_r};
          acpu_pkg::OP_ADDX: acc_nxt = acc_r + x_r;
          acpu_pkg::OP_ADDY: acc_nxt = acc_r + y_r;
          acpu_pkg::OP_SUBX: acc_nxt = acc_r - x_r;
          acpu_pkg::OP_SUBY: acc_nxt = acc_r - y_r;
          acpu_pkg::OP_TOX:  x_nxt = acc_r;
          acpu_pkg::OP_FRX:  acc_nxt = x_r;
          acpu_pkg::OP_TOY:  y_nxt = acc_r;
          acpu_pkg::OP_FRY:  acc_nxt = y_r;
          acpu_pkg::OP_TOSP: sp_nxt = acc_r;
          acpu_pkg::OP_FRSP: acc_nxt = sp_r;
          acpu_pkg::OP_JMP, acpu_pkg::OP_JEQ, acpu_pkg::OP_JNE: begin
            if (m_rd == acpu_pkg::OP_JMP || (m_rd == acpu_pkg::OP_JEQ && acc_r == '0)
                || (m_rd == acpu_pkg::OP_JNE && acc_r != '0)) begin
              t_nxt = pc_r + 32'd1; st_nxt = acpu_pkg::S_RD1;
            end else pc_nxt = pc_r + 32'd1;
          end
          acpu_pkg::OP_CALL: begin
            sp_nxt = sp_r - 32'd1; t_nxt = sp_r - 32'd1; st_nxt = acpu_pkg::S_WR;
          end
          acpu_pkg::OP_RET, acpu_pkg::OP_POP, acpu_pkg::OP_IRET: begin
            t_nxt = sp_r; st_nxt = acpu_pkg::S_RD1;
          end
          acpu_pkg::OP_INCX: x_nxt = x_r + 32'd1;
          acpu_pkg::OP_DECX: x_nxt = x_r - 32'd1;
          acpu_pkg::OP_PUSH: begin
            sp_nxt = sp_r - 32'd1; t_nxt = sp_r - 32'd1; st_nxt = acpu_pkg::S_WR;
          end
          acpu_pkg::OP_INT: begin
            sv_nxt = sp_r; sys_nxt = 1'b1; sp_nxt = MEM_TOP - 32'd1;
            st_nxt = acpu_pkg::S_IRQ1;
          end
          acpu_pkg::OP_END: begin
            halt_nxt = 1'b1; stat_nxt = acpu_pkg::ST_END; st_nxt = acpu_pkg::S_DONE;
          end
          default: ;
        endcase
      end
      // issue read at t_r
      acpu_pkg::S_RD1, acpu_pkg::S_RD3: begin
        m_a = t_r;
        if (!a_ok) begin
          halt_nxt = 1'b1; stat_nxt = acpu_pkg::ST_FAULT; st_nxt = acpu_pkg::S_DONE;
        end else st_nxt = acpu_pkg::S_RD2;
      end
      // read data back: decide next access
      acpu_pkg::S_RD2: begin
        st_nxt = acpu_pkg::S_POST;
        ph_nxt = ph_r + 2'd1;
        case (ir_r)
          acpu_pkg::OP_LDV, acpu_pkg::OP_LDSP, acpu_pkg::OP_POP: begin
            acc_nxt = m_rd;
            if (ir_r == acpu_pkg::OP_POP) sp_nxt = sp_r + 32'd1;
          end
          acpu_pkg::OP_LDA: begin
            if (ph_r == 2'd0) begin t_nxt = m_rd; st_nxt = acpu_pkg::S_RD3; end
            else acc_nxt = m_rd;
          end
          acpu_pkg::OP_LDI: begin
            if (ph_r != 2'd2) begin t_nxt = m_rd; st_nxt = acpu_pkg::S_RD3; end
            else acc_nxt = m_rd;
          end
          acpu_pkg::OP_LDX, acpu_pkg::OP_LDY: begin
            if (ph_r == 2'd0) begin
              t_nxt = m_rd + ((ir_r == acpu_pkg::OP_LDX) ? x_r : y_r);
              st_nxt = acpu_pkg::S_RD3;
            end else acc_nxt = m_rd;
          end
          acpu_pkg::OP_ST: begin t_nxt = m_rd; st_nxt = acpu_pkg::S_WR; end
          acpu_pkg::OP_PUT: begin put_nxt = 1'b1; ischar_nxt = (m_rd != 32'd1); end
          acpu_pkg::OP_JMP, acpu_pkg::OP_JEQ, acpu_pkg::OP_JNE, acpu_pkg::OP_CALL:
            pc_nxt = m_rd - 32'd1;
          acpu_pkg::OP_RET: begin pc_nxt = m_rd - 32'd1; sp_nxt = sp_r + 32'd1; end
          acpu_pkg::OP_IRET: begin
            if (ph_r == 2'd0) begin
              sv_nxt = m_rd; sp_nxt = sp_r + 32'd1; t_nxt = sp_r + 32'd1;
              st_nxt = acpu_pkg::S_RD3;
            end else begin
              pc_nxt = sv_r; sp_nxt = m_rd; sys_nxt = 1'b0;
              if (tirq_r) begin cnt_nxt = '0; tirq_nxt = 1'b0; end
            end
          end
          default: ;
        endcase
      end
      acpu_pkg::S_WR: begin
        m_a = t_r;
        m_wd = (ir_r == acpu_pkg::OP_CALL) ? pc_r + 32'd2 : acc_r;
        if (!a_ok) begin
          halt_nxt = 1'b1; stat_nxt = acpu_pkg::ST_FAULT; st_nxt = acpu_pkg::S_DONE;
        end else begin
          m_we = 1'b1;
          if (ir_r == acpu_pkg::OP_CALL) begin
            t_nxt = pc_r + 32'd1; st_nxt = acpu_pkg::S_RD1;
          end else st_nxt = acpu_pkg::S_POST;
        end
      end
      // interrupt entry: save old sp then pc
      acpu_pkg::S_IRQ1: begin
        m_a = sp_r; m_wd = sv_r;
        if (!a_ok) begin
          halt_nxt = 1'b1; stat_nxt = acpu_pkg::ST_FAULT; st_nxt = acpu_pkg::S_DONE;
        end else begin
          m_we = 1'b1; sp_nxt = sp_r - 32'd1; st_nxt = acpu_pkg::S_IRQ2;
        end
      end
      acpu_pkg::S_IRQ2: begin
        m_a = sp_r; m_wd = pc_r;
        if (!a_ok) begin
          halt_nxt = 1'b1; stat_nxt = acpu_pkg::ST_FAULT; st_nxt = acpu_pkg::S_DONE;
        end else begin
          m_we = 1'b1;
          pc_nxt = tirq_r ? acpu_pkg::TIMER_VEC_M1 : acpu_pkg::SYS_VEC_M1;
          if (ph_r == 2'd3) begin
            pc_nxt = acpu_pkg::TIMER_VEC_M1 + 32'd1;
            stat_nxt = acpu_pkg::ST_OK; st_nxt = acpu_pkg::S_DONE;
          end else st_nxt = acpu_pkg::S_POST;
        end
      end
      // count, timer check, pc increment
      acpu_pkg::S_POST: begin
        stat_nxt = acpu_pkg::ST_OK;
        st_nxt = acpu_pkg::S_DONE;
        pc_nxt = pc_r + 32'd1;
        if (!sys_r) begin
          logic [31:0] c;
          c = (ir_r != acpu_pkg::OP_IRET) ? cnt_r + 32'd1 : cnt_r;
          cnt_nxt = c;
          if (c == {16'd0, period_r}) begin
            tirq_nxt = 1'b1; ir_nxt = acpu_pkg::OP_INT; sv_nxt = sp_r;
            sys_nxt = 1'b1; sp_nxt = MEM_TOP - 32'd1; pc_nxt = pc_r;
            ph_nxt = 2'd3; st_nxt = acpu_pkg::S_IRQ1;
          end
        end
      end
      acpu_pkg::S_DONE: st_nxt = acpu_pkg::S_IDLE;
      default: st_nxt = acpu_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= acpu_pkg::S_IDLE; pc_r <= '0; acc_r <= '0; x_r <= '0; y_r <= '0;
      sp_r <= acpu_pkg::USER_SP_RST; ir_r <= '0; cnt_r <= '0; sys_r <= 1'b0;
      tirq_r <= 1'b0; halt_r <= 1'b0; ph_r <= '0; put_r <= 1'b0; ischar_r <= 1'b0;
      stat_r <= '0;
    end else begin
      st_r <= st_nxt; pc_r <= pc_nxt; acc_r <= acc_nxt; x_r <= x_nxt; y_r <= y_nxt;
      sp_r <= sp_nxt; ir_r <= ir_nxt; cnt_r <= cnt_nxt; sys_r <= sys_nxt;
      tirq_r <= tirq_nxt; halt_r <= halt_nxt; ph_r <= ph_nxt; put_r <= put_nxt;
      ischar_r <= ischar_nxt; stat_r <= stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r <= t_nxt; sv_r <= sv_nxt;
  end

  // outputs: strobe, valid, char and value in DONE only; status is stat_r
  assign out_strobe  = (st_r == acpu_pkg::S_DONE);
  assign out_status  = stat_r;
  assign out_valid   = out_strobe && put_r && (stat_r == acpu_pkg::ST_OK);
  assign out_is_char = out_valid && ischar_r;
  assign out_value   = out_valid ? acc_r : '0;

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("strobe while idle");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("double result");
  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r) else $error("halt cleared");
  a_put_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == acpu_pkg::ST_OK) else $error("put with bad status");
endmodule

/* tb/accumulator_cpu_with_timer_irq_tb.sv */
// Testbench for accumulator_cpu_with_timer_irq: loads a generated program, steps it
// through several timer settings and checks every answer against an in-bench predictor.
// Depends on acpu_pkg and the block's RTL.
`timescale 1ns / 1ps

module accumulator_cpu_with_timer_irq_tb;

  localparam int MEM_W = acpu_pkg::MEM_WORDS_DEF;

  // return codes of one executed instruction
  localparam int RUN_CNT   = 0;
  localparam int RUN_UNCNT = 1;
  localparam int RUN_END   = 2;
  localparam int RUN_FAULT = 3;

  // program layout
  localparam int CODE_END  = 880;  // JMP 0 sits here
  localparam int SUB_ADDR  = 890;  // subroutine: a lone RET
  localparam int PTR_BASE  = 900;  // 900..949 pointers into 900..999
  localparam int DATA_BASE = 950;  // 950..999 scratch for LDA/ST
  localparam int TMR_ISR   = 1000;
  localparam int SYS_ISR   = 1500;

  typedef struct packed {
    logic [1:0]  status;
    logic        vld;
    logic        chr;
    logic [31:0] val;
  } cpu_res_t;

  logic        clk, rst_n;
  logic        start, busy;
  logic        in_command;
  logic [10:0] in_load_address;
  logic [31:0] in_load_data;
  logic [6:0]  in_random_value;
  logic        out_strobe;
  logic [1:0]  out_status;
  logic        out_valid, out_is_char;
  logic [31:0] out_value;
  logic        cfg_valid, cfg_ready;
  logic [15:0] cfg_timer_period;

  accumulator_cpu_with_timer_irq dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_load_address(in_load_address),
    .in_load_data(in_load_data), .in_random_value(in_random_value),
    .out_strobe(out_strobe), .out_status(out_status), .out_valid(out_valid),
    .out_is_char(out_is_char), .out_value(out_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_timer_period(cfg_timer_period)
  );

  // predicted CPU state
  logic [31:0] mem_img [MEM_W];
  logic [31:0] pc_q, acc_q, ix_q, iy_q, sp_q, ucnt_q;
  logic        sysm_q, tmr_q, halt_q;
  logic [15:0] period_q;

  cpu_res_t answer_q[$];
  int n_err, n_load, n_step, n_put, n_irq_entry;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5ms;
    $display("accumulator_cpu_with_timer_irq test failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit addr_legal(input logic [31:0] a);
    return (a < 32'(MEM_W)) && (sysm_q || a <= acpu_pkg::USER_TOP);
  endfunction

  function automatic bit mem_read(input logic [31:0] a, output logic [31:0] v);
    v = '0;
    if (!addr_legal(a)) return 1'b0;
    v = mem_img[a[10:0]];
    return 1'b1;
  endfunction

  function automatic bit mem_write(input logic [31:0] a, input logic [31:0] v);
    if (!addr_legal(a)) return 1'b0;
    mem_img[a[10:0]] = v;
    return 1'b1;
  endfunction

  // push sp and pc on the system stack, then vector
  function automatic bit enter_irq();
    logic [31:0] saved;
    saved  = sp_q;
    sysm_q = 1'b1;
    sp_q   = 32'(MEM_W - 1);
    if (!mem_write(sp_q, saved)) return 1'b0;
    sp_q--;
    if (!mem_write(sp_q, pc_q)) return 1'b0;
    pc_q = tmr_q ? acpu_pkg::TIMER_VEC_M1 : acpu_pkg::SYS_VEC_M1;
    return 1'b1;
  endfunction

  function automatic int run_instr(input logic [31:0] ir, input logic [31:0] rnd,
                                   output bit put, output logic [31:0] port);
    logic [31:0] a, b;
    put = 1'b0;
    port = '0;
    a = '0;
    b = '0;
    case (ir)
      acpu_pkg::OP_LDV: begin
        pc_q++;
        if (!mem_read(pc_q, acc_q)) return RUN_FAULT;
      end
      acpu_pkg::OP_LDA: begin
        pc_q++;
        if (!mem_read(pc_q, a) || !mem_read(a, acc_q)) return RUN_FAULT;
      end
      acpu_pkg::OP_LDI: begin
        pc_q++;
        if (!mem_read(pc_q, a) || !mem_read(a, b) || !mem_read(b, acc_q)) return RUN_FAULT;
      end
      acpu_pkg::OP_LDX, acpu_pkg::OP_LDY: begin
        pc_q++;
        if (!mem_read(pc_q, a)) return RUN_FAULT;
        a += (ir == acpu_pkg::OP_LDX) ? ix_q : iy_q;
        if (!mem_read(a, acc_q)) return RUN_FAULT;
      end
      acpu_pkg::OP_LDSP: if (!mem_read(ix_q + sp_q, acc_q)) return RUN_FAULT;
      acpu_pkg::OP_ST: begin
        pc_q++;
        if (!mem_read(pc_q, a) || !mem_write(a, acc_q)) return RUN_FAULT;
      end
      acpu_pkg::OP_GET:  acc_q = rnd;
      acpu_pkg::OP_PUT: begin
        pc_q++;
        if (!mem_read(pc_q, port)) return RUN_FAULT;
        put = 1'b1;
      end
      acpu_pkg::OP_ADDX: acc_q += ix_q;
      acpu_pkg::OP_ADDY: acc_q += iy_q;
      acpu_pkg::OP_SUBX: acc_q -= ix_q;
      acpu_pkg::OP_SUBY: acc_q -= iy_q;
      acpu_pkg::OP_TOX:  ix_q = acc_q;
      acpu_pkg::OP_FRX:  acc_q = ix_q;
      acpu_pkg::OP_TOY:  iy_q = acc_q;
      acpu_pkg::OP_FRY:  acc_q = iy_q;
      acpu_pkg::OP_TOSP: sp_q = acc_q;
      acpu_pkg::OP_FRSP: acc_q = sp_q;
      acpu_pkg::OP_JMP, acpu_pkg::OP_JEQ, acpu_pkg::OP_JNE: begin
        if (ir == acpu_pkg::OP_JMP || (ir == acpu_pkg::OP_JEQ && acc_q == 32'd0)
            || (ir == acpu_pkg::OP_JNE && acc_q != 32'd0)) begin
          if (!mem_read(pc_q + 32'd1, a)) return RUN_FAULT;
          pc_q = a - 32'd1;
        end else begin
          pc_q++;
        end
      end
      acpu_pkg::OP_CALL: begin
        sp_q--;
        if (!mem_write(sp_q, pc_q + 32'd2)) return RUN_FAULT;
        if (!mem_read(pc_q + 32'd1, a)) return RUN_FAULT;
        pc_q = a - 32'd1;
      end
      acpu_pkg::OP_RET: begin
        if (!mem_read(sp_q, a)) return RUN_FAULT;
        sp_q++;
        pc_q = a - 32'd1;
      end
      acpu_pkg::OP_INCX: ix_q++;
      acpu_pkg::OP_DECX: ix_q--;
      acpu_pkg::OP_PUSH: begin
        sp_q--;
        if (!mem_write(sp_q, acc_q)) return RUN_FAULT;
      end
      acpu_pkg::OP_POP: begin
        if (!mem_read(sp_q, acc_q)) return RUN_FAULT;
        sp_q++;
      end
      acpu_pkg::OP_INT: if (!enter_irq()) return RUN_FAULT;
      acpu_pkg::OP_IRET: begin
        if (!mem_read(sp_q, a)) return RUN_FAULT;
        sp_q++;
        if (!mem_read(sp_q, b)) return RUN_FAULT;
        pc_q   = a;
        sp_q   = b;
        sysm_q = 1'b0;
        if (tmr_q) begin
          ucnt_q = '0;
          tmr_q  = 1'b0;
        end
        return RUN_UNCNT;
      end
      acpu_pkg::OP_END: return RUN_END;
      default: ;  // unknown opcode: counted no-op
    endcase
    return RUN_CNT;
  endfunction

  function automatic cpu_res_t predict_answer(input bit cmd, input logic [10:0] addr,
                                             input logic [31:0] data, input logic [6:0] rnd);
    cpu_res_t r;
    logic [31:0] ir, port;
    bit put;
    int k;
    r = '0;
    if (!cmd) begin
      if (addr < 11'(MEM_W)) mem_img[addr] = data;
      r.status = halt_q ? acpu_pkg::ST_HALTED : acpu_pkg::ST_OK;
      return r;
    end
    if (halt_q) begin
      r.status = acpu_pkg::ST_HALTED;
      return r;
    end
    if (!mem_read(pc_q, ir)) begin
      halt_q = 1'b1;
      r.status = acpu_pkg::ST_FAULT;
      return r;
    end
    k = run_instr(ir, {25'd0, rnd}, put, port);
    if (k == RUN_FAULT || k == RUN_END) begin
      halt_q = 1'b1;
      r.status = (k == RUN_END) ? acpu_pkg::ST_END : acpu_pkg::ST_FAULT;
      return r;
    end
    if (k == RUN_CNT && !sysm_q) ucnt_q++;
    if (!sysm_q && ucnt_q == {16'd0, period_q}) begin
      tmr_q = 1'b1;
      n_irq_entry++;
      if (!enter_irq()) begin
        halt_q = 1'b1;
        r.status = acpu_pkg::ST_FAULT;
        return r;
      end
    end
    pc_q++;
    if (put) begin
      r.vld = 1'b1;
      r.chr = (port != 32'd1);
      r.val = acc_q;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    cpu_res_t e;
    if (rst_n && out_strobe) begin
      if (answer_q.size() == 0) begin
        $error("answer with no request outstanding: status %0d", out_status);
        n_err++;
      end else begin
        e = answer_q.pop_front();
        if (out_valid) n_put++;
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          n_err++;
        end
        if (out_valid !== e.vld) begin
          $error("out_valid: expected %0d, got %0d", e.vld, out_valid);
          n_err++;
        end
        if (out_is_char !== e.chr) begin
          $error("out_is_char: expected %0d, got %0d", e.chr, out_is_char);
          n_err++;
        end
        if (out_value !== e.val) begin
          $error("out_value: expected %0d, got %0d", $signed(e.val), $signed(out_value));
          n_err++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic issue_request(input bit cmd, input logic [10:0] addr,
                               input logic [31:0] data, input logic [6:0] rnd);
    @(negedge clk);
    start           <= 1'b1;
    in_command      <= cmd;
    in_load_address <= addr;
    in_load_data    <= data;
    in_random_value <= rnd;
    do @(posedge clk); while (busy);
    answer_q.push_back(predict_answer(cmd, addr, data, rnd));
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic idle_gap(input int pct);
    while ($urandom_range(0, 99) < pct) @(negedge clk);
  endtask

  task automatic load_word(input logic [10:0] addr, input logic [31:0] data, input int pct);
    idle_gap(pct);
    issue_request(1'b0, addr, data, 7'($urandom));
    n_load++;
  endtask

  task automatic step_cpu(input int pct);
    idle_gap(pct);
    issue_request(1'b1, 11'($urandom), $urandom, 7'($urandom));
    n_step++;
  endtask

  task automatic drain_answers();
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_period(input logic [15:0] per);
    drain_answers();
    repeat (3) @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_timer_period <= per;
    do @(posedge clk); while (!cfg_ready);
    period_q = per;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset();
    start = 1'b0;
    in_command = 1'b0;
    in_load_address = '0;
    in_load_data = '0;
    in_random_value = '0;
    cfg_valid = 1'b0;
    cfg_timer_period = '0;
    rst_n = 1'b0;
    pc_q = '0; acc_q = '0; ix_q = '0; iy_q = '0; ucnt_q = '0;
    sp_q = acpu_pkg::USER_SP_RST;
    sysm_q = 1'b0; tmr_q = 1'b0; halt_q = 1'b0;
    period_q = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  endtask

  // Writes a random but well-formed program: straight-line code, paired stack use,
  // jumps to the next instruction, calls to a lone RET, and both handlers.
  task automatic test_program_load();
    int p, i;
    logic [31:0] op;
    p = 0;
    while (p < CODE_END - 4) begin
      case ($urandom_range(0, 14))
        0: begin
          load_word(11'(p), acpu_pkg::OP_LDV, 0);
          load_word(11'(p + 1), $urandom, 0);
          p += 2;
        end
        1: begin load_word(11'(p), acpu_pkg::OP_GET, 0); p += 1; end
        2, 3: begin
          load_word(11'(p), acpu_pkg::OP_PUT, 0);
          load_word(11'(p + 1), $urandom_range(0, 1) ? 32'd1 : $urandom, 0);
          p += 2;
        end
        4: begin
          load_word(11'(p), acpu_pkg::OP_ADDX + $urandom_range(0, 3), 0);
          p += 1;
        end
        5: begin
          case ($urandom_range(0, 6))
            0: op = acpu_pkg::OP_TOX;
            1: op = acpu_pkg::OP_FRX;
            2: op = acpu_pkg::OP_TOY;
            3: op = acpu_pkg::OP_FRY;
            4: op = acpu_pkg::OP_FRSP;
            5: op = acpu_pkg::OP_INCX;
            default: op = acpu_pkg::OP_DECX;
          endcase
          load_word(11'(p), op, 0);
          p += 1;
        end
        6: begin
          load_word(11'(p), acpu_pkg::OP_LDA, 0);
          load_word(11'(p + 1), $urandom_range(PTR_BASE, 999), 0);
          p += 2;
        end
        7: begin
          load_word(11'(p), acpu_pkg::OP_LDI, 0);
          load_word(11'(p + 1), $urandom_range(PTR_BASE, DATA_BASE - 1), 0);
          p += 2;
        end
        8: begin
          load_word(11'(p), acpu_pkg::OP_ST, 0);
          load_word(11'(p + 1), $urandom_range(DATA_BASE, 999), 0);
          p += 2;
        end
        9: begin
          load_word(11'(p), acpu_pkg::OP_PUSH, 0);
          load_word(11'(p + 1), acpu_pkg::OP_POP, 0);
          p += 2;
        end
        10: begin
          load_word(11'(p), acpu_pkg::OP_JMP + $urandom_range(0, 2), 0);
          load_word(11'(p + 1), 32'(p + 2), 0);
          p += 2;
        end
        11: begin
          load_word(11'(p), acpu_pkg::OP_CALL, 0);
          load_word(11'(p + 1), 32'(SUB_ADDR), 0);
          p += 2;
        end
        12: begin load_word(11'(p), acpu_pkg::OP_INT, 0); p += 1; end
        default: begin
          // unknown opcode: zero, the gap below End, or anything large
          case ($urandom_range(0, 2))
            0: op = 32'd0;
            1: op = 32'd31 + $urandom_range(0, 18);
            default: op = $urandom | 32'h100;
          endcase
          load_word(11'(p), op, 0);
          p += 1;
        end
      endcase
    end
    while (p < CODE_END) begin load_word(11'(p), acpu_pkg::OP_INCX, 0); p += 1; end
    load_word(11'(CODE_END), acpu_pkg::OP_JMP, 0);
    load_word(11'(CODE_END + 1), 32'd0, 0);
    load_word(11'(SUB_ADDR), acpu_pkg::OP_RET, 0);
    for (i = PTR_BASE; i < DATA_BASE; i++)
      load_word(11'(i), $urandom_range(PTR_BASE, 999), 0);
    for (i = DATA_BASE; i < 1000; i++) load_word(11'(i), $urandom, 0);
    // timer handler: puts sp as an integer
    load_word(11'(TMR_ISR),     acpu_pkg::OP_INCX, 0);
    load_word(11'(TMR_ISR + 1), acpu_pkg::OP_FRSP, 0);
    load_word(11'(TMR_ISR + 2), acpu_pkg::OP_PUT, 0);
    load_word(11'(TMR_ISR + 3), 32'd1, 0);
    load_word(11'(TMR_ISR + 4), acpu_pkg::OP_IRET, 0);
    // syscall handler
    load_word(11'(SYS_ISR),     acpu_pkg::OP_GET, 0);
    load_word(11'(SYS_ISR + 1), acpu_pkg::OP_PUT, 0);
    load_word(11'(SYS_ISR + 2), $urandom, 0);
    load_word(11'(SYS_ISR + 3), acpu_pkg::OP_TOY, 0);
    load_word(11'(SYS_ISR + 4), acpu_pkg::OP_IRET, 0);
    // out-of-range loads are ignored
    load_word(11'd2000, 32'hFFFF_FFFF, 0);
    load_word(11'd2047, 32'h8000_0000, 0);
  endtask

  task automatic test_directed_steps();
    int i;
    set_period(16'hFFFF);
    for (i = 0; i < 20; i++) step_cpu(0);
  endtask

  // steps with occasional scratch reloads as noise
  task automatic test_random_run(input int n, input int pct, input logic [15:0] per);
    int i;
    set_period(per);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 14) == 0)
        load_word(11'($urandom_range(DATA_BASE, 998)), $urandom, pct);
      else
        step_cpu(pct);
      if ($urandom_range(0, 149) == 0) drain_answers();
    end
  endtask

  // period 0 written while a timer interrupt is in service: each Iret re-fires it
  task automatic test_zero_period();
    int i;
    set_period(16'((ucnt_q + 3) & 32'hFFFF));
    for (i = 0; i < 300 && !tmr_q; i++) step_cpu(0);
    set_period(16'd0);
    for (i = 0; i < 60; i++) step_cpu(35);
  endtask

  // End halts; afterwards steps and loads answer halted
  task automatic test_halt();
    drain_answers();
    load_word(pc_q[10:0], acpu_pkg::OP_END, 0);
    step_cpu(0);
    step_cpu(0);
    load_word(11'(DATA_BASE), $urandom, 0);
    load_word(11'd2047, $urandom, 0);
  endtask

  initial begin
    n_err = 0; n_load = 0; n_step = 0; n_put = 0; n_irq_entry = 0;
    test_reset();
    set_period(16'd0);
    test_program_load();
    test_directed_steps();
    test_random_run(150, 0,  16'hFFFF);
    test_random_run(150, 68, 16'((ucnt_q + 7) & 32'hFFFF));
    drain_answers();  // sender holds until everything is answered
    test_random_run(150, 0,  16'((ucnt_q + 3) & 32'hFFFF));
    test_random_run(150, 35, 16'((ucnt_q + 11) & 32'hFFFF));
    test_zero_period();
    test_random_run(80, 68, 16'd1);
    test_halt();
    drain_answers();
    repeat (20) @(posedge clk);
    $display("covered %0d loads and %0d steps, %0d puts, %0d timer interrupts",
             n_load, n_step, n_put, n_irq_entry);
    $display("timer settings 0, 1, 65535 and near-count values; run ended halted");
    if (n_err == 0) begin
      $display("accumulator_cpu_with_timer_irq test passed");
    end else begin
      $display("accumulator_cpu_with_timer_irq test failed");
    end
    $finish;
  end

endmodule
